// ----- hdl/tsat_pkg.sv -----
// Package for the 2-SAT solver core: sizes, command and status codes,
// and the controller state type. No dependencies.
`default_nettype none
package tsat_pkg;
	localparam int MAX_VARS  = 64;
	localparam int MAX_EDGES = 1024;
	localparam int EAW       = $clog2(MAX_EDGES);
	localparam int ECW       = EAW + 1;
	localparam int VXW       = 7;
	localparam int VCAP      = 2 * MAX_VARS;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_SOLVE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] STS_ADDED = 3'd0;
	localparam logic [2:0] STS_FULL  = 3'd1;
	localparam logic [2:0] STS_RANGE = 3'd2;
	localparam logic [2:0] STS_SAT   = 3'd3;
	localparam logic [2:0] STS_UNSAT = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE, S_ADD_B, S_ADD_RES, S_CLR, S_F_RD, S_F_CHK, S_NXT,
		S_R_FO, S_R_MK, S_R_CHK, S_W_RD, S_W_EV, S_W_MK, S_W_FIN, S_W_POP,
		S_C_RD0, S_C_RD1, S_C_CMP, S_A_CLR, S_A_FO, S_A_VR, S_A_UP,
		S_E_RD, S_E_OUT, S_U_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- hdl/two_sat_solver_core.sv -----
// A satisfiable solve returns its n results, one per variable; the walk scans the
// edge memory anew for each vertex, through its single read port.
// One transaction in flight at a time. Async reset clears control state and the edge
// count; memories are not cleared, marks and assignments are cleared within each solve.
// Depends on tsat_pkg and tsat_ram.
`default_nettype none
module two_sat_solver_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_data,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [6:0] from_vertex,
	input  wire logic [6:0] to_vertex,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [2:0]      status,
	output logic [5:0]      var_index,
	output logic            var_value,
	output logic            last
);
	import tsat_pkg::*;

	state_t state_q, state_nxt;

	logic [6:0]     nvars_q, n_eff;
	logic [7:0]     nv;
	logic [ECW-1:0] ec_q;
	logic [7:0]     i_q, sp_q, label_q, nfin_q, a_q;
	logic           side_q;
	logic [6:0]     cur_vtx_q, w_q, u_q, v_q;
	logic [ECW-1:0] cur_pos_q;
	logic [2:0]     res_st_q;

	logic           ov_q, last_q, val_q;
	logic [2:0]     status_q;
	logic [5:0]     idx_q;

	logic acc, ofree, range_bad, full, add_ok;
	logic [6:0] ef, et, ew;
	logic stale, hit, mark_zero, i_last_nv, i_last_n, i_last_fin;

	logic           e_we;
	logic [EAW-1:0] e_waddr;
	logic [13:0]    e_wdata, e_rd;
	logic           m_we;
	logic [6:0]     m_waddr, m_raddr;
	logic [7:0]     m_wdata, m_rd;
	logic           f_we;
	logic [6:0]     f_rd;
	logic [6:0]     f_raddr;
	logic           k_we;
	logic [17:0]    k_rd;
	logic           v_we;
	logic [5:0]     v_waddr, v_raddr;
	logic [1:0]     v_wdata, v_rd;

	assign n_eff = (nvars_q == 7'd0) ? 7'd1 :
		(nvars_q > 7'(MAX_VARS)) ? 7'(MAX_VARS) : nvars_q;
	assign nv = {n_eff, 1'b0};

	assign item_ready = (state_q == S_IDLE);
	assign acc = item_valid && item_ready;
	assign ofree = !ov_q || result_ready;
	assign range_bad = ({1'b0, from_vertex} >= nv) || ({1'b0, to_vertex} >= nv);
	assign full = ({1'b0, ec_q} + 12'd2) > 12'(MAX_EDGES);
	assign add_ok = !range_bad && !full;

	assign ef = e_rd[13:7];
	assign et = e_rd[6:0];
	assign stale = ({1'b0, ef} >= nv) || ({1'b0, et} >= nv);
	assign hit = !stale && ((side_q ? et : ef) == cur_vtx_q);
	assign ew = side_q ? ef : et;
	assign mark_zero = (m_rd == 8'd0);
	assign i_last_nv = (i_q + 8'd1) == nv;
	assign i_last_n = (i_q + 8'd1) == {1'b0, n_eff};
	assign i_last_fin = (i_q + 8'd1) == nfin_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_ADD:   state_nxt = add_ok ? S_ADD_B : S_ADD_RES;
						CMD_SOLVE: state_nxt = S_CLR;
						default:   state_nxt = S_IDLE;
					endcase
				end
			end
			S_ADD_B:   state_nxt = S_ADD_RES;
			S_ADD_RES: if (ofree) state_nxt = S_IDLE;
			S_CLR:     if (i_last_nv) state_nxt = side_q ? S_R_FO : S_F_RD;
			S_F_RD:    state_nxt = S_F_CHK;
			S_F_CHK:   state_nxt = mark_zero ? S_W_RD : S_NXT;
			S_NXT: begin
				if (!side_q) begin
					state_nxt = i_last_nv ? S_CLR : S_F_RD;
				end else begin
					state_nxt = (i_q == 8'd0) ? S_C_RD0 : S_R_FO;
				end
			end
			S_R_FO:    state_nxt = S_R_MK;
			S_R_MK:    state_nxt = S_R_CHK;
			S_R_CHK:   state_nxt = mark_zero ? S_W_RD : S_NXT;
			S_W_RD:    state_nxt = (cur_pos_q >= ec_q) ? S_W_FIN : S_W_EV;
			S_W_EV:    state_nxt = hit ? S_W_MK : S_W_RD;
			S_W_MK:    state_nxt = S_W_RD;
			S_W_FIN:   state_nxt = (sp_q == 8'd1) ? S_NXT : S_W_POP;
			S_W_POP:   state_nxt = S_W_RD;
			S_C_RD0:   state_nxt = S_C_RD1;
			S_C_RD1:   state_nxt = S_C_CMP;
			S_C_CMP: begin
				if (a_q == m_rd) state_nxt = S_U_OUT;
				else if (i_last_n) state_nxt = S_A_CLR;
				else state_nxt = S_C_RD0;
			end
			S_A_CLR:   if (i_last_n) state_nxt = S_A_FO;
			S_A_FO:    state_nxt = S_A_VR;
			S_A_VR:    state_nxt = S_A_UP;
			S_A_UP:    state_nxt = i_last_fin ? S_E_RD : S_A_FO;
			S_E_RD:    state_nxt = S_E_OUT;
			S_E_OUT:   if (ofree) state_nxt = i_last_n ? S_IDLE : S_E_RD;
			S_U_OUT:   if (ofree) state_nxt = S_IDLE;
			default:   state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		e_we = 1'b0;
		e_waddr = ec_q[EAW-1:0];
		e_wdata = {from_vertex, to_vertex};
		m_we = 1'b0;
		m_waddr = i_q[6:0];
		m_wdata = 8'd0;
		m_raddr = i_q[6:0];
		f_we = (state_q == S_W_FIN) && !side_q;
		f_raddr = i_q[6:0];
		k_we = (state_q == S_W_MK) && mark_zero;
		v_we = 1'b0;
		v_waddr = i_q[5:0];
		v_wdata = 2'b00;
		v_raddr = i_q[5:0];
		case (state_q)
			S_IDLE:  e_we = acc && (cmd == CMD_ADD) && add_ok;
			S_ADD_B: begin
				e_we = 1'b1;
				e_waddr = ec_q[EAW-1:0] + EAW'(1);
				e_wdata = {v_q ^ 7'd1, u_q ^ 7'd1};
			end
			S_CLR:   m_we = 1'b1;
			S_F_CHK: begin
				m_we = mark_zero;
				m_wdata = 8'd1;
			end
			S_R_MK:  m_raddr = f_rd;
			S_R_CHK: begin
				m_we = mark_zero;
				m_waddr = cur_vtx_q;
				m_wdata = label_q + 8'd1;
			end
			S_W_EV:  m_raddr = ew;
			S_W_MK: begin
				m_we = mark_zero;
				m_waddr = w_q;
				m_wdata = side_q ? label_q : 8'd1;
			end
			S_C_RD0: m_raddr = {i_q[5:0], 1'b0};
			S_C_RD1: m_raddr = {i_q[5:0], 1'b1};
			S_A_CLR: v_we = 1'b1;
			S_A_VR:  v_raddr = f_rd[6:1];
			S_A_UP: begin
				v_we = !v_rd[1];
				v_waddr = w_q[6:1];
				v_wdata = {1'b1, ~w_q[0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nvars_q <= 7'd1;
			ec_q <= '0;
			i_q <= 8'd0;
			sp_q <= 8'd0;
			label_q <= 8'd0;
			nfin_q <= 8'd0;
			side_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) nvars_q <= cfg_data;
			if (ov_q && result_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc && cmd == CMD_CLEAR) ec_q <= '0;
					if (acc && cmd == CMD_SOLVE) begin
						i_q <= 8'd0;
						side_q <= 1'b0;
						nfin_q <= 8'd0;
						label_q <= 8'd0;
					end
				end
				S_ADD_B: ec_q <= ec_q + ECW'(2);
				S_ADD_RES, S_U_OUT: if (ofree) ov_q <= 1'b1;
				S_CLR: i_q <= i_last_nv ? (side_q ? nfin_q - 8'd1 : 8'd0) : i_q + 8'd1;
				S_F_CHK, S_R_CHK: begin
					if (mark_zero) sp_q <= 8'd1;
					if (mark_zero && state_q == S_R_CHK) label_q <= label_q + 8'd1;
				end
				S_NXT: begin
					if (!side_q) begin
						if (i_last_nv) begin
							side_q <= 1'b1;
							i_q <= 8'd0;
						end else begin
							i_q <= i_q + 8'd1;
						end
					end else if (i_q != 8'd0) begin
						i_q <= i_q - 8'd1;
					end
				end
				S_W_MK:  if (mark_zero) sp_q <= sp_q + 8'd1;
				S_W_FIN: begin
					sp_q <= sp_q - 8'd1;
					if (!side_q) nfin_q <= nfin_q + 8'd1;
				end
				S_C_CMP: i_q <= i_last_n ? 8'd0 : i_q + 8'd1;
				S_A_CLR: i_q <= i_last_n ? 8'd0 : i_q + 8'd1;
				S_A_UP:  i_q <= i_last_fin ? 8'd0 : i_q + 8'd1;
				S_E_OUT: begin
					if (ofree) begin
						ov_q <= 1'b1;
						i_q <= i_q + 8'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				u_q <= from_vertex;
				v_q <= to_vertex;
				res_st_q <= range_bad ? STS_RANGE : (full ? STS_FULL : STS_ADDED);
			end
			S_ADD_RES: if (ofree) begin
				status_q <= res_st_q;
				idx_q <= 6'd0;
				val_q <= 1'b0;
				last_q <= 1'b1;
			end
			S_U_OUT: if (ofree) begin
				status_q <= STS_UNSAT;
				idx_q <= 6'd0;
				val_q <= 1'b0;
				last_q <= 1'b1;
			end
			S_E_OUT: if (ofree) begin
				status_q <= STS_SAT;
				idx_q <= i_q[5:0];
				val_q <= v_rd[0];
				last_q <= i_last_n;
			end
			S_F_CHK: begin
				cur_vtx_q <= i_q[6:0];
				cur_pos_q <= '0;
			end
			S_R_MK:  cur_vtx_q <= f_rd;
			S_R_CHK: cur_pos_q <= '0;
			S_W_EV: begin
				cur_pos_q <= cur_pos_q + ECW'(1);
				w_q <= ew;
			end
			S_W_MK: if (mark_zero) begin
				cur_vtx_q <= w_q;
				cur_pos_q <= '0;
			end
			S_W_POP: begin
				cur_vtx_q <= k_rd[17:11];
				cur_pos_q <= k_rd[10:0];
			end
			S_C_RD1: a_q <= m_rd;
			S_A_VR:  w_q <= f_rd;
			default: ;
		endcase
	end

	tsat_ram #(.DEPTH(MAX_EDGES), .WIDTH(14)) u_edge (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(cur_pos_q[EAW-1:0]), .rdata(e_rd)
	);
	tsat_ram #(.DEPTH(VCAP), .WIDTH(8)) u_mark (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rd)
	);
	tsat_ram #(.DEPTH(VCAP), .WIDTH(7)) u_fin (
		.clk(clk), .we(f_we), .waddr(nfin_q[6:0]), .wdata(cur_vtx_q),
		.raddr(f_raddr), .rdata(f_rd)
	);
	tsat_ram #(.DEPTH(VCAP), .WIDTH(18)) u_stack (
		.clk(clk), .we(k_we), .waddr(7'(sp_q - 8'd1)), .wdata({cur_vtx_q, cur_pos_q}),
		.raddr(7'(sp_q - 8'd2)), .rdata(k_rd)
	);
	tsat_ram #(.DEPTH(MAX_VARS), .WIDTH(2)) u_var (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rd)
	);

	assign result_valid = ov_q;
	assign status = status_q;
	assign var_index = idx_q;
	assign var_value = val_q;
	assign last = last_q;

	a_pairs: assert property (@(posedge clk) disable iff (!arst_n) ec_q[0] == 1'b0)
		else $error("edge count not even");
	a_idle_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (sp_q == 8'd0))
		else $error("walk stack not empty at idle");
	a_stack_cap: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= 8'(VCAP))
		else $error("walk stack overflow");
	a_fin_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && !side_q) |-> (nfin_q <= nv))
		else $error("finish order overflow");
endmodule
`default_nettype wire

// ----- hdl/tsat_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module tsat_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
